### rtl/unsorted_array_min_priority_queue_defines.svh
// ------------------------------------------------------------------------
// unsorted array min priority queue assertion macros
// shared helpers for concurrent checks on clk with active-low reset
// ------------------------------------------------------------------------
`ifndef UNSORTED_ARRAY_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define UNSORTED_ARRAY_MIN_PRIORITY_QUEUE_DEFINES_SVH

// property must hold at every edge outside reset
`define UAMPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define UAMPQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/uampq_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// uampq_pkg
// types, codes and sizes shared by the priority queue controller,
// datapath and top level
// ------------------------------------------------------------------------
package uampq_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int LEN_W       = 7;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                    action;
        logic signed [VALUE_WIDTH-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] removed_value;
        logic [1:0]                    status;
        logic [LEN_W-1:0]              length;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_scan;
        logic last_issue;
        logic out_free;
    } sts_t;

endpackage

### rtl/uampq_ctrl.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// uampq_ctrl
// request sequencer: accepts one request, runs the minimum scan for a
// remove, then commits the update and the result in one step
// ------------------------------------------------------------------------
module uampq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  uampq_pkg::sts_t   sts,
    output uampq_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.start_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.last_issue)
                begin
                    state_next = S_DRAIN;
                end
            end
            // last read data is compared here
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

### rtl/uampq_dp.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// uampq_dp
// entry memory, count, scan comparator and result register of the
// priority queue
// ------------------------------------------------------------------------
`include "unsorted_array_min_priority_queue_defines.svh"

module uampq_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  uampq_pkg::req_t   req,
    input  uampq_pkg::cmd_t   cmd,
    output uampq_pkg::sts_t   sts,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output uampq_pkg::rsp_t   rsp
);

    localparam int IDX_W = uampq_pkg::IDX_W;
    localparam int LEN_W = uampq_pkg::LEN_W;
    localparam int VW    = uampq_pkg::VALUE_WIDTH;

    logic signed [VW-1:0]    mem [uampq_pkg::CAPACITY];

    uampq_pkg::req_t         req_reg;
    logic [LEN_W-1:0]        count_reg;
    logic [LEN_W-1:0]        count_next;
    logic [IDX_W-1:0]        scan_idx_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic signed [VW-1:0]    rd_data_reg;
    logic signed [VW-1:0]    best_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic signed [VW-1:0]    last_reg;
    logic                    out_valid_reg;
    uampq_pkg::rsp_t         out_reg;
    uampq_pkg::rsp_t         out_next;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VW-1:0]    wr_data;
    logic                    is_full;

    assign is_full = (count_reg == LEN_W'(uampq_pkg::CAPACITY));

    assign sts.start_scan = (req.action == uampq_pkg::ACT_REMOVE) && (count_reg != '0);
    assign sts.last_issue = (LEN_W'(scan_idx_reg) == count_reg - LEN_W'(1));
    assign sts.out_free   = !out_valid_reg || !rsp_stall;

    // commit step: state update and result word
    always_comb
    begin
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IDX_W-1:0];
        wr_data    = req_reg.value;
        out_next   = '0;
        case (req_reg.action)
            uampq_pkg::ACT_INSERT:
            begin
                if (is_full)
                begin
                    out_next.status = uampq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + LEN_W'(1);
                end
            end
            uampq_pkg::ACT_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    out_next.status = uampq_pkg::ST_EMPTY;
                end
                else
                begin
                    // last entry fills the hole left by the minimum
                    wr_en                  = 1'b1;
                    wr_addr                = best_idx_reg;
                    wr_data                = last_reg;
                    out_next.removed_value = best_reg;
                    count_next             = count_reg - LEN_W'(1);
                end
            end
            uampq_pkg::ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        out_next.length = count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (cmd.accept)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            if (cmd.finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
        if (cmd.scan)
        begin
            rd_idx_reg <= scan_idx_reg;
        end
        if (rd_vld_reg)
        begin
            last_reg <= rd_data_reg;
            // strict less keeps the lowest index among equal minima
            if (rd_idx_reg == '0 || rd_data_reg < best_reg)
            begin
                best_reg     <= rd_data_reg;
                best_idx_reg <= rd_idx_reg;
            end
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `UAMPQ_NEVER(a_count_range, count_reg > LEN_W'(uampq_pkg::CAPACITY), "count above capacity")
    `UAMPQ_NEVER(a_scan_range, cmd.scan && (LEN_W'(scan_idx_reg) >= count_reg), "scan past count")
    `UAMPQ_ASSERT(a_remove_dec, cmd.finish && req_reg.action == uampq_pkg::ACT_REMOVE && count_reg != '0 |=> count_reg == $past(count_reg) - LEN_W'(1), "remove did not decrement count")
    `UAMPQ_ASSERT(a_len_match, cmd.finish |=> rsp_valid && rsp.length == count_reg, "reported length differs from count")

endmodule

### rtl/unsorted_array_min_priority_queue.sv
`timescale 1ns / 1ps
// insert, clear and unused codes: no scan; the request goes straight to the commit step,
//   and the result is registered once the output register is free
// remove: scan of the occupied entries through the single memory read port, one per cycle,
//   then the commit step; a remove on an empty queue skips the scan
// results wait in an output register; a new request is taken once the previous result is loaded
// reset clears the count and handshake state; entry contents are undefined until written
// ------------------------------------------------------------------------
// unsorted_array_min_priority_queue
// min priority queue over an unsorted entry memory with sequential scan
// ------------------------------------------------------------------------
module unsorted_array_min_priority_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  uampq_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output uampq_pkg::rsp_t   rsp
);

    uampq_pkg::cmd_t cmd;
    uampq_pkg::sts_t sts;

    uampq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    uampq_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
